// ===== rtl/mnt_pkg.sv =====
// Shared types and constants for the modular number theory unit.
package mnt_pkg;

  localparam int OPERAND_WIDTH_DEF = 31;
  localparam int MOD_W             = 31;
  localparam int DEN_W             = 32;
  localparam int DIV_W             = 2 * DEN_W;
  localparam int RESULT_W          = 62;
  localparam int COEF_W            = DEN_W + 2;
  localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(1000000007);

  typedef enum logic [1:0] {
    OP_GCD = 2'd0,
    OP_LCM = 2'd1,
    OP_POW = 2'd2,
    OP_INV = 2'd3
  } op_t;

  typedef struct packed {
    logic [DIV_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic [DIV_W-1:0] quotient;
    logic [DEN_W-1:0] remainder;
  } div_rsp_t;

endpackage

// ===== rtl/mnt_ifs.sv =====
// Request, response and configuration channels of the modular number theory unit.
interface mnt_req_if import mnt_pkg::*; #(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
);
  logic                     valid;
  logic                     ready;
  logic [1:0]               req_type;
  logic [OPERAND_WIDTH-1:0] operand_a;
  logic [OPERAND_WIDTH-1:0] operand_b;
  modport source (output valid, req_type, operand_a, operand_b, input ready);
  modport sink (input valid, req_type, operand_a, operand_b, output ready);
endinterface

interface mnt_rsp_if import mnt_pkg::*;;
  logic                valid;
  logic                ready;
  logic [RESULT_W-1:0] result;
  logic                error;
  modport source (output valid, result, error, input ready);
  modport sink (input valid, result, error, output ready);
endinterface

interface mnt_cfg_if import mnt_pkg::*;;
  logic             valid;
  logic             ready;
  logic [MOD_W-1:0] modulus;
  modport source (output valid, modulus, input ready);
  modport sink (input valid, modulus, output ready);
endinterface

// ===== rtl/mnt_divider.sv =====
// Restoring shift-subtract divider, one quotient bit per cycle.
module mnt_divider import mnt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  div_req_t req_in,
  output logic     done,
  output div_rsp_t rsp_out
);

  localparam int CNT_W = $clog2(DIV_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DIV_W-1:0] quo;
  logic [DEN_W-1:0] den;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  always_comb begin
    trial = {rem, quo[DIV_W-1]};
    ge    = trial >= {1'b0, den};
    diff  = trial - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= req_in.dividend;
      rem <= '0;
      den <= req_in.divisor;
    end else if (busy) begin
      rem <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo <= {quo[DIV_W-2:0], ge};
    end
  end

  assign rsp_out.quotient  = quo;
  assign rsp_out.remainder = rem;

endmodule

// ===== rtl/modular_number_theory_unit.sv =====
// Top level of the modular number theory unit: sequencer, multiplier and registers.
//
// Each request carries an opcode and two unsigned operands and gives exactly one
// response. Opcode 0 returns gcd(a, b) by Euclid, opcode 1 returns lcm(a, b) as
// a*b/gcd (both operands zero sets error and returns 0), opcode 2 returns a to
// the power b modulo the configured modulus by square-and-multiply (exponent 0
// gives 1), and opcode 3 returns the extended-Euclid coefficient of a, brought
// into the range [0, modulus), which is the inverse when gcd(a, modulus) is 1.
// A modulus of 0 behaves as 1. All divisions and reductions run through one
// shared restoring divider, and one 32 by 32 bit multiplier with a registered
// product feeds it. A gcd takes one division per Euclid step (at most about 46
// steps for 31-bit operands), an lcm adds one product and one more division, a
// modular power needs one reduction of the base plus a product, a squaring and
// two reductions per exponent bit that is set (a squaring and one reduction per
// clear bit, the last squaring skipped), and an inverse takes one division and
// one product per Euclid step. The unit takes one request at a time: req.ready
// is high only while the sequencer is idle. The finished result sits in an
// output register until it is taken on rsp, and the modulus register is written
// through cfg only while the unit is idle and no request is offered in the same
// cycle.
module modular_number_theory_unit import mnt_pkg::*; #(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input logic     clk,
  input logic     rst,
  mnt_req_if.sink req,
  mnt_rsp_if.source rsp,
  mnt_cfg_if.sink cfg
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_G_CHK, ST_G_WAIT, ST_L_MUL, ST_L_DIV, ST_L_WAIT,
    ST_P_RED, ST_P_RWAIT, ST_P_CHK, ST_P_MUL, ST_P_MDIV, ST_P_MWAIT,
    ST_P_SQ, ST_P_SDIV, ST_P_SWAIT, ST_I_CHK, ST_I_WAIT, ST_I_MUL,
    ST_I_UPD, ST_I_FIX, ST_FINISH
  } state_t;

  state_t state;

  // Configuration: the modulus register, ready while the sequencer is idle and
  // no request competes for the same edge.
  logic [MOD_W-1:0] modulus;
  logic [DEN_W-1:0] m_eff;

  assign cfg.ready = (state == ST_IDLE) && !req.valid;
  assign m_eff     = (modulus == '0) ? DEN_W'(1) : DEN_W'(modulus);

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MOD_RESET;
    end else if (cfg.valid && cfg.ready) begin
      modulus <= cfg.modulus;
    end
  end

  // Request operands, taken in their low OPERAND_WIDTH bits.
  logic [DEN_W-1:0] in_a;
  logic [DEN_W-1:0] in_b;

  assign in_a = DEN_W'(req.operand_a[OPERAND_WIDTH-1:0]);
  assign in_b = DEN_W'(req.operand_b[OPERAND_WIDTH-1:0]);

  // Working registers of the sequencer.
  op_t                 op;
  logic [DEN_W-1:0]    opa;
  logic [DEN_W-1:0]    opb;
  logic [DEN_W-1:0]    u;
  logic [DEN_W-1:0]    v;
  logic [DEN_W-1:0]    acc;
  logic [DEN_W-1:0]    base;
  logic [DEN_W-1:0]    ex;
  logic [DEN_W-1:0]    q;
  logic [COEF_W-1:0]   p;
  logic [COEF_W-1:0]   r;
  logic [DIV_W-1:0]    prod;
  logic [RESULT_W-1:0] res;
  logic                err;
  logic                rsp_valid;

  // Shared multiplier with a registered product.
  logic [DEN_W-1:0] mul_x;
  logic [DEN_W-1:0] mul_y;
  logic [DEN_W-1:0] p_mag;

  assign p_mag = p[COEF_W-1] ? DEN_W'(-p) : DEN_W'(p);

  always_comb begin
    unique case (state)
      ST_L_MUL: begin
        mul_x = opa;
        mul_y = opb;
      end
      ST_P_MUL: begin
        mul_x = acc;
        mul_y = base;
      end
      ST_P_SQ: begin
        mul_x = base;
        mul_y = base;
      end
      ST_I_MUL: begin
        mul_x = q;
        mul_y = p_mag;
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_x * mul_y;
  end

  // Shared divider and its operand selection.
  logic     div_start;
  logic     div_done;
  div_req_t div_req;
  div_rsp_t div_rsp;

  always_comb begin
    div_start = 1'b0;
    div_req   = '{dividend: prod, divisor: m_eff};
    unique case (state)
      ST_G_CHK: begin
        div_start = (u != '0);
        div_req   = '{dividend: DIV_W'(v), divisor: u};
      end
      ST_L_DIV: begin
        div_start = 1'b1;
        div_req   = '{dividend: prod, divisor: v};
      end
      ST_P_RED: begin
        div_start = 1'b1;
        div_req   = '{dividend: DIV_W'(opa), divisor: m_eff};
      end
      ST_P_MDIV, ST_P_SDIV: begin
        div_start = 1'b1;
      end
      ST_I_CHK: begin
        div_start = (u != '0);
        div_req   = '{dividend: DIV_W'(v), divisor: u};
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  mnt_divider u_divider (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .req_in  (div_req),
    .done    (div_done),
    .rsp_out (div_rsp)
  );

  // Coefficient update and final range fix for the inverse.
  logic [COEF_W-1:0] qp;
  logic [COEF_W-1:0] m_c;
  logic [COEF_W-1:0] fix_t;
  logic [COEF_W-1:0] fix_x;

  always_comb begin
    qp    = p[COEF_W-1] ? -COEF_W'(prod) : COEF_W'(prod);
    m_c   = COEF_W'(m_eff);
    fix_t = r[COEF_W-1] ? r + m_c : r;
    fix_x = (fix_t >= m_c) ? fix_t - m_c : fix_t;
  end

  assign req.ready  = (state == ST_IDLE);
  assign rsp.valid  = rsp_valid;

  // Sequencer: state and registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      // In ST_FINISH a response that is taken is replaced by the new one below.
      if (rsp_valid && rsp.ready && state != ST_FINISH) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req.valid) begin
            op  <= op_t'(req.req_type);
            opa <= in_a;
            opb <= in_b;
            u   <= in_a;
            unique case (op_t'(req.req_type))
              OP_GCD: begin
                v     <= in_b;
                err   <= 1'b0;
                state <= ST_G_CHK;
              end
              OP_LCM: begin
                v <= in_b;
                if (in_a == '0 && in_b == '0) begin
                  err   <= 1'b1;
                  res   <= '0;
                  state <= ST_FINISH;
                end else begin
                  err   <= 1'b0;
                  state <= ST_G_CHK;
                end
              end
              OP_POW: begin
                ex    <= in_b;
                err   <= 1'b0;
                state <= ST_P_RED;
              end
              OP_INV: begin
                v     <= m_eff;
                p     <= COEF_W'(1);
                r     <= '0;
                err   <= 1'b0;
                state <= ST_I_CHK;
              end
            endcase
          end
        end
        ST_G_CHK: begin
          if (u == '0) begin
            if (op == OP_GCD) begin
              res   <= RESULT_W'(v);
              state <= ST_FINISH;
            end else begin
              state <= ST_L_MUL;
            end
          end else begin
            state <= ST_G_WAIT;
          end
        end
        ST_G_WAIT: begin
          if (div_done) begin
            v     <= u;
            u     <= div_rsp.remainder;
            state <= ST_G_CHK;
          end
        end
        ST_L_MUL: state <= ST_L_DIV;
        ST_L_DIV: state <= ST_L_WAIT;
        ST_L_WAIT: begin
          if (div_done) begin
            res   <= RESULT_W'(div_rsp.quotient);
            state <= ST_FINISH;
          end
        end
        ST_P_RED: state <= ST_P_RWAIT;
        ST_P_RWAIT: begin
          if (div_done) begin
            base  <= div_rsp.remainder;
            acc   <= DEN_W'(1);
            state <= ST_P_CHK;
          end
        end
        ST_P_CHK: begin
          if (ex == '0) begin
            res   <= RESULT_W'(acc);
            state <= ST_FINISH;
          end else if (ex[0]) begin
            state <= ST_P_MUL;
          end else begin
            state <= ST_P_SQ;
          end
        end
        ST_P_MUL: state <= ST_P_MDIV;
        ST_P_MDIV: state <= ST_P_MWAIT;
        ST_P_MWAIT: begin
          if (div_done) begin
            acc   <= div_rsp.remainder;
            state <= ST_P_SQ;
          end
        end
        ST_P_SQ: begin
          // The last squaring is skipped since nothing reads it.
          ex <= ex >> 1;
          if (ex[DEN_W-1:1] == '0) begin
            state <= ST_P_CHK;
          end else begin
            state <= ST_P_SDIV;
          end
        end
        ST_P_SDIV: state <= ST_P_SWAIT;
        ST_P_SWAIT: begin
          if (div_done) begin
            base  <= div_rsp.remainder;
            state <= ST_P_CHK;
          end
        end
        ST_I_CHK: begin
          if (u == '0) begin
            state <= ST_I_FIX;
          end else begin
            state <= ST_I_WAIT;
          end
        end
        ST_I_WAIT: begin
          if (div_done) begin
            q     <= div_rsp.quotient[DEN_W-1:0];
            v     <= u;
            u     <= div_rsp.remainder;
            state <= ST_I_MUL;
          end
        end
        ST_I_MUL: state <= ST_I_UPD;
        ST_I_UPD: begin
          r     <= p;
          p     <= r - qp;
          state <= ST_I_CHK;
        end
        ST_I_FIX: begin
          res   <= RESULT_W'(fix_x);
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid  <= 1'b1;
            rsp.result <= res;
            rsp.error  <= err;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // The divider only reports completion while the sequencer waits on it.
  a_div_done_busy: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state != ST_IDLE && state != ST_FINISH))
    else $error("divider finished while sequencer was not waiting");

  // An error response always carries a zero result.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.error) |-> (rsp.result == '0))
    else $error("error response with nonzero result");

  // After a request is taken the unit is busy in the next cycle.
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("ready right after an accepted request");

  // A new response is loaded only when the output register is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && rsp_valid && !rsp.ready) |=> state == ST_FINISH)
    else $error("response overwritten while stalled");
`endif

endmodule

// ===== verif/modular_number_theory_unit_checker.sv =====
// Checker for the modular number theory unit: predicts each response and compares it.
module modular_number_theory_unit_checker import mnt_pkg::*; (
  input logic clk,
  input logic rst,
  mnt_req_if  req,
  mnt_rsp_if  rsp,
  mnt_cfg_if  cfg,
  output int  fail_count,
  output int  outstanding
);

  typedef struct {
    logic [RESULT_W-1:0] result;
    logic                error;
  } answer_t;

  answer_t                 answer_q[$];
  logic [MOD_W-1:0]        modulus_reg;

  function automatic longint unsigned gcd_of(longint unsigned a, longint unsigned b);
    longint unsigned t;
    for (int i = 0; i < 96 && a != 0; i++) begin
      t = a;
      a = b % a;
      b = t;
    end
    return b;
  endfunction

  function automatic longint unsigned pow_mod(longint unsigned base, longint unsigned ex,
                                              longint unsigned m);
    longint unsigned acc;
    acc  = 1;
    base = base % m;
    for (int i = 0; i < 64 && ex != 0; i++) begin
      if (ex[0]) acc = (acc * base) % m;
      ex   = ex >> 1;
      base = (base * base) % m;
    end
    return acc;
  endfunction

  // Extended Euclid coefficient of a, reduced into [0, m) even with no inverse.
  function automatic longint unsigned inv_mod(longint unsigned a, longint unsigned m);
    longint          p, r, q, np, x;
    longint unsigned u, v, nu;
    p = 1;
    r = 0;
    u = a;
    v = m;
    for (int i = 0; i < 96 && u != 0; i++) begin
      q  = longint'(v / u);
      np = r - q * p;
      nu = v % u;
      r  = p;
      p  = np;
      v  = u;
      u  = nu;
    end
    x = r % longint'(m);
    if (x < 0) x += longint'(m);
    return longint'(x);
  endfunction

  function automatic answer_t predict_answer(op_t op, longint unsigned a,
                                             longint unsigned b);
    answer_t         ans;
    longint unsigned m;
    m          = (modulus_reg == '0) ? 64'd1 : 64'(modulus_reg);
    ans.error  = 1'b0;
    ans.result = '0;
    case (op)
      OP_GCD: ans.result = RESULT_W'(gcd_of(a, b));
      OP_LCM: begin
        if (a == 0 && b == 0) ans.error = 1'b1;
        else ans.result = RESULT_W'((a * b) / gcd_of(a, b));
      end
      OP_POW: ans.result = RESULT_W'(pow_mod(a, b, m));
      default: ans.result = RESULT_W'(inv_mod(a, m));
    endcase
    return ans;
  endfunction

  assign outstanding = answer_q.size();

  always @(posedge clk) begin
    answer_t exp_ans;
    if (rst) begin
      modulus_reg <= MOD_RESET;
      answer_q.delete();
      fail_count  <= 0;
    end else begin
      if (cfg.valid && cfg.ready) modulus_reg <= cfg.modulus;
      if (req.valid && req.ready)
        answer_q.insert(answer_q.size(),
                        predict_answer(op_t'(req.req_type), 64'(req.operand_a),
                                       64'(req.operand_b)));
      if (rsp.valid && rsp.ready) begin
        if (answer_q.size() == 0) begin
          $display("%0t: response with none pending: result %0d error %0b",
                   $time, rsp.result, rsp.error);
          fail_count <= fail_count + 1;
        end else begin
          exp_ans = answer_q.pop_front();
          if (exp_ans.result !== rsp.result || exp_ans.error !== rsp.error) begin
            $display("%0t: mismatch: expected result %0d error %0b, got result %0d error %0b",
                     $time, exp_ans.result, exp_ans.error, rsp.result, rsp.error);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// ===== verif/modular_number_theory_unit_tb.sv =====
// Testbench top of the modular number theory unit: clock, reset, stimulus and verdict.
module modular_number_theory_unit_tb;
  import mnt_pkg::*;

  localparam logic [30:0] OP_MAX = 31'h7fffffff;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   outstanding;
  int   sent;
  bit   quiet;        // no idling on either side in the closing stretch
  int   stall_left;

  mnt_req_if req_ch();
  mnt_rsp_if rsp_ch();
  mnt_cfg_if cfg_ch();

  modular_number_theory_unit dut (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch), .cfg(cfg_ch)
  );

  modular_number_theory_unit_checker checker_i (
    .clk(clk), .rst(rst), .req(req_ch), .rsp(rsp_ch), .cfg(cfg_ch),
    .fail_count(fail_count), .outstanding(outstanding)
  );

  always #1 clk = ~clk;

  // Response side: random bursts of back-pressure, none once the run is quiet.
  always @(posedge clk) begin
    if (rst || quiet) begin
      rsp_ch.ready <= 1'b1;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 15);
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // Operands lean toward zero, all ones, small values and random bit lengths, so
  // Euclid runs both short and long and every operand bit toggles.
  function automatic logic [30:0] pick_operand();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return OP_MAX;
      2: return 31'($urandom_range(1, 1000));
      default: return 31'($urandom) >> $urandom_range(0, 30);
    endcase
  endfunction

  // One request. The leading edge keeps valid from being lowered and raised in
  // one time step; valid drops right after the request is taken.
  task automatic send_request(op_t op, logic [30:0] a, logic [30:0] b);
    @(posedge clk);
    if (!quiet && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 16)) @(posedge clk);
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= op;
    req_ch.operand_a <= a;
    req_ch.operand_b <= b;
    do @(posedge clk); while (!req_ch.ready);
    req_ch.valid <= 1'b0;
    sent++;
    quiet = (sent >= 120);
  endtask

  // The modulus changes only with the unit drained and idle.
  task automatic write_modulus(logic [30:0] value);
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_ch.valid   <= 1'b1;
    cfg_ch.modulus <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_requests(int count);
    for (int i = 0; i < count; i++)
      send_request(op_t'($urandom_range(0, 3)), pick_operand(), pick_operand());
  endtask

  initial begin
    logic [30:0] moduli[5];
    req_ch.valid     <= 1'b0;
    req_ch.req_type  <= OP_GCD;
    req_ch.operand_a <= '0;
    req_ch.operand_b <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.modulus   <= '0;
    sent  = 0;
    quiet = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed cases under the reset modulus: zero and full-scale operands, the
    // gcd of zeros, lcm with zero operands, a zero exponent and a zero to invert.
    send_request(OP_GCD, 0, 0);
    send_request(OP_GCD, 0, 12345);
    send_request(OP_GCD, OP_MAX, OP_MAX);
    send_request(OP_GCD, 1836311903, 1134903170);
    send_request(OP_LCM, 0, 0);
    send_request(OP_LCM, 0, 77);
    send_request(OP_LCM, OP_MAX, OP_MAX - 1);
    send_request(OP_LCM, 12, 18);
    send_request(OP_POW, 0, 0);
    send_request(OP_POW, 12345, 0);
    send_request(OP_POW, OP_MAX, OP_MAX);
    send_request(OP_POW, 2, 1000000005);
    send_request(OP_INV, 0, 0);
    send_request(OP_INV, 3, OP_MAX);
    send_request(OP_INV, OP_MAX, 0);
    send_request(OP_INV, 1000000007, 5);

    // Modulus sweep: one, the largest, zero (acts as one), a composite where many
    // values have no inverse, then a random one.
    moduli = '{31'd1, OP_MAX, 31'd0, 31'd12, 31'($urandom) | 31'd2};
    foreach (moduli[k]) begin
      write_modulus(moduli[k]);
      send_request(OP_POW, 7, 0);
      send_request(OP_INV, 8, 0);
      random_requests(22);
    end

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("modular_number_theory_unit regression: pass");
    else
      $display("modular_number_theory_unit regression: fail");
    $finish;
  end

  initial begin
    #8000000;
    $display("modular_number_theory_unit regression: fail");
    $finish;
  end

endmodule
